/* design/incp_pkg.sv */
// Package for the incremental PID servo block: register map, widths,
// reset values and the configuration struct. No dependencies.
`default_nettype none

package incp_pkg;

    localparam int GAIN_WIDTH             = 24;
    localparam int LIMIT_WIDTH            = 16;
    localparam int DRIVE_WIDTH            = 16;
    localparam int CFG_INDEX_WIDTH        = 3;
    localparam int CFG_DATA_WIDTH         = GAIN_WIDTH;
    localparam int DEFAULT_POSITION_WIDTH = 16;
    localparam int DEFAULT_FRACTION_BITS  = 16;

    localparam logic signed [GAIN_WIDTH-1:0] RESET_GAIN_P = 24'sd16384;
    localparam logic signed [GAIN_WIDTH-1:0] RESET_GAIN_I = 24'sd393;
    localparam logic signed [GAIN_WIDTH-1:0] RESET_GAIN_D = -24'sd66;
    localparam logic signed [GAIN_WIDTH-1:0] RESET_BIAS   = 24'sd0;
    localparam logic [LIMIT_WIDTH-1:0]       RESET_UPPER  = 16'd1000;
    localparam logic [LIMIT_WIDTH-1:0]       RESET_LOWER  = 16'd600;
    localparam logic [LIMIT_WIDTH-1:0]       RESET_START  = 16'd750;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_GAIN_P        = 3'd0,
        CFG_GAIN_I        = 3'd1,
        CFG_GAIN_D        = 3'd2,
        CFG_BIAS_PER_STEP = 3'd3,
        CFG_UPPER_LIMIT   = 3'd4,
        CFG_LOWER_LIMIT   = 3'd5,
        CFG_START_OUTPUT  = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [GAIN_WIDTH-1:0] gain_p;
        logic signed [GAIN_WIDTH-1:0] gain_i;
        logic signed [GAIN_WIDTH-1:0] gain_d;
        logic signed [GAIN_WIDTH-1:0] bias_per_step;
        logic [LIMIT_WIDTH-1:0]       upper_limit;
        logic [LIMIT_WIDTH-1:0]       lower_limit;
        logic [LIMIT_WIDTH-1:0]       start_output;
        logic                         reload;
    } cfg_t;

endpackage

`default_nettype wire

/* design/incp_if.sv */
// Stream interfaces of the incremental PID servo block: position samples in,
// drive values out. Depends on incp_pkg for default widths.
`default_nettype none

interface incp_in_if #(
    parameter int POSITION_WIDTH = incp_pkg::DEFAULT_POSITION_WIDTH
) ();
    logic                             valid;
    logic                             ready;
    logic signed [POSITION_WIDTH-1:0] measured_position;
    logic signed [POSITION_WIDTH-1:0] target_position;

    modport source (output valid, output measured_position, output target_position,
                    input ready);
    modport sink   (input valid, input measured_position, input target_position,
                    output ready);
endinterface

interface incp_out_if ();
    logic                                 valid;
    logic                                 ready;
    logic [incp_pkg::DRIVE_WIDTH-1:0]     drive_value;

    modport source (output valid, output drive_value, input ready);
    modport sink   (input valid, input drive_value, output ready);
endinterface

`default_nettype wire

/* design/incp_cfg_regs.sv */
// Configuration register file of the incremental PID servo block.
// Depends on incp_pkg for the register map and cfg_t.
`default_nettype none

module incp_cfg_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire incp_pkg::cfg_index_t                 cfg_index,
    input  wire logic [incp_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output incp_pkg::cfg_t                            cfg
);
    import incp_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p        <= RESET_GAIN_P;
            cfg_reg.gain_i        <= RESET_GAIN_I;
            cfg_reg.gain_d        <= RESET_GAIN_D;
            cfg_reg.bias_per_step <= RESET_BIAS;
            cfg_reg.upper_limit   <= RESET_UPPER;
            cfg_reg.lower_limit   <= RESET_LOWER;
            cfg_reg.start_output  <= RESET_START;
            cfg_reg.reload        <= 1'b0;
        end
        else
        begin
            cfg_reg.reload <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GAIN_P:        cfg_reg.gain_p        <= $signed(cfg_data);
                    CFG_GAIN_I:        cfg_reg.gain_i        <= $signed(cfg_data);
                    CFG_GAIN_D:        cfg_reg.gain_d        <= $signed(cfg_data);
                    CFG_BIAS_PER_STEP: cfg_reg.bias_per_step <= $signed(cfg_data);
                    CFG_UPPER_LIMIT:   cfg_reg.upper_limit   <= cfg_data[LIMIT_WIDTH-1:0];
                    CFG_LOWER_LIMIT:   cfg_reg.lower_limit   <= cfg_data[LIMIT_WIDTH-1:0];
                    CFG_START_OUTPUT:
                    begin
                        cfg_reg.start_output <= cfg_data[LIMIT_WIDTH-1:0];
                        cfg_reg.reload       <= 1'b1;
                    end
                    default:           cfg_reg.reload        <= 1'b0;
                endcase
            end
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* design/incp_product_stage.sv */
// Input register, error forming and gain products of the incremental PID
// servo block. Depends on incp_pkg and incp_in_if.
`default_nettype none

module incp_product_stage #(
    parameter int POSITION_WIDTH = incp_pkg::DEFAULT_POSITION_WIDTH,
    localparam int ERR_WIDTH  = POSITION_WIDTH + 1,
    localparam int DIFF_WIDTH = POSITION_WIDTH + 2,
    localparam int PD_WIDTH   = incp_pkg::GAIN_WIDTH + 1 + DIFF_WIDTH,
    localparam int PI_WIDTH   = incp_pkg::GAIN_WIDTH + ERR_WIDTH
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    incp_in_if.sink                         position,
    input  wire incp_pkg::cfg_t             cfg,
    output logic                            prod_valid,
    input  wire logic                       prod_ready,
    output logic signed [PD_WIDTH-1:0]      prod_d,
    output logic signed [PI_WIDTH-1:0]      prod_i
);
    import incp_pkg::*;

    localparam int GPD_WIDTH = GAIN_WIDTH + 1;

    logic                             s1_valid_reg;
    logic signed [POSITION_WIDTH-1:0] meas_reg;
    logic signed [POSITION_WIDTH-1:0] targ_reg;
    logic signed [ERR_WIDTH-1:0]      prev_error_reg;
    logic                             prod_valid_reg;
    logic signed [PD_WIDTH-1:0]       prod_d_reg;
    logic signed [PI_WIDTH-1:0]       prod_i_reg;

    logic                             s2_ready;
    logic                             s1_fire;
    logic signed [ERR_WIDTH-1:0]      error_next;
    logic signed [DIFF_WIDTH-1:0]     diff;
    logic signed [GPD_WIDTH-1:0]      gain_pd;

    assign s2_ready       = !prod_valid_reg || prod_ready;
    assign s1_fire        = s1_valid_reg && s2_ready;
    assign position.ready = !s1_valid_reg || s2_ready;

    // kp*(e - p) + kd*(p - e) folds into (kp - kd)*(e - p)
    assign error_next = ERR_WIDTH'(targ_reg) - ERR_WIDTH'(meas_reg);
    assign diff       = DIFF_WIDTH'(error_next) - DIFF_WIDTH'(prev_error_reg);
    assign gain_pd    = GPD_WIDTH'(cfg.gain_p) - GPD_WIDTH'(cfg.gain_d);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            prev_error_reg <= '0;
        end
        else
        begin
            if (position.ready)
            begin
                s1_valid_reg <= position.valid;
            end
            if (s2_ready)
            begin
                prod_valid_reg <= s1_valid_reg;
            end
            if (s1_fire)
            begin
                prev_error_reg <= error_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (position.ready && position.valid)
        begin
            meas_reg <= position.measured_position;
            targ_reg <= position.target_position;
        end
        if (s1_fire)
        begin
            prod_d_reg <= PD_WIDTH'(gain_pd) * PD_WIDTH'(diff);
            prod_i_reg <= PI_WIDTH'(cfg.gain_i) * PI_WIDTH'(error_next);
        end
    end

    assign prod_valid = prod_valid_reg;
    assign prod_d     = prod_d_reg;
    assign prod_i     = prod_i_reg;

endmodule

`default_nettype wire

/* design/incp_accum_stage.sv */
// Output accumulator, clamp and result register of the incremental PID
// servo block. Depends on incp_pkg and incp_out_if.
`default_nettype none

module incp_accum_stage #(
    parameter int POSITION_WIDTH = incp_pkg::DEFAULT_POSITION_WIDTH,
    parameter int FRACTION_BITS  = incp_pkg::DEFAULT_FRACTION_BITS,
    localparam int PD_WIDTH = incp_pkg::GAIN_WIDTH + 1 + POSITION_WIDTH + 2,
    localparam int PI_WIDTH = incp_pkg::GAIN_WIDTH + POSITION_WIDTH + 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire incp_pkg::cfg_t             cfg,
    input  wire logic                       prod_valid,
    output logic                            prod_ready,
    input  wire logic signed [PD_WIDTH-1:0] prod_d,
    input  wire logic signed [PI_WIDTH-1:0] prod_i,
    incp_out_if.source                      drive
);
    import incp_pkg::*;

    localparam int ACC_WIDTH  = LIMIT_WIDTH + FRACTION_BITS;
    localparam int PROD_MAX   = (PD_WIDTH > PI_WIDTH) ? PD_WIDTH : PI_WIDTH;
    localparam int BASE_WIDTH = (PROD_MAX > ACC_WIDTH + 1) ? PROD_MAX : ACC_WIDTH + 1;
    localparam int SUM_WIDTH  = BASE_WIDTH + 3;

    logic [ACC_WIDTH-1:0]         acc_reg;
    logic                         out_valid_reg;
    logic [DRIVE_WIDTH-1:0]       drive_reg;

    logic                         fire;
    logic signed [SUM_WIDTH-1:0]  sum;
    logic signed [SUM_WIDTH-1:0]  lo_q;
    logic signed [SUM_WIDTH-1:0]  hi_q;
    logic [ACC_WIDTH-1:0]         acc_next;

    assign prod_ready = !out_valid_reg || drive.ready;
    assign fire       = prod_valid && prod_ready;

    assign sum = SUM_WIDTH'($signed({1'b0, acc_reg})) + SUM_WIDTH'(prod_d)
               + SUM_WIDTH'(prod_i) + SUM_WIDTH'(cfg.bias_per_step);
    assign lo_q = SUM_WIDTH'($signed({1'b0, cfg.lower_limit, {FRACTION_BITS{1'b0}}}));
    assign hi_q = SUM_WIDTH'($signed({1'b0, cfg.upper_limit, {FRACTION_BITS{1'b0}}}));

    always_comb
    begin
        priority if (sum < lo_q)
        begin
            acc_next = {cfg.lower_limit, {FRACTION_BITS{1'b0}}};
        end
        else if (sum > hi_q)
        begin
            acc_next = {cfg.upper_limit, {FRACTION_BITS{1'b0}}};
        end
        else
        begin
            acc_next = sum[ACC_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= {RESET_START, {FRACTION_BITS{1'b0}}};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (cfg.reload)
            begin
                acc_reg <= {cfg.start_output, {FRACTION_BITS{1'b0}}};
            end
            else if (fire)
            begin
                acc_reg <= acc_next;
            end
            else
            begin
                acc_reg <= acc_reg;
            end
            if (prod_ready)
            begin
                out_valid_reg <= prod_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            drive_reg <= acc_next[ACC_WIDTH-1:FRACTION_BITS];
        end
    end

    assign drive.valid       = out_valid_reg;
    assign drive.drive_value = drive_reg;

endmodule

`default_nettype wire

/* design/incremental_pid_clamped_unit.sv */
// Top level of the incremental PID servo block with clamped Q accumulator.
// Depends on incp_pkg, incp_if, incp_cfg_regs, incp_product_stage, incp_accum_stage.
//
//   port      role    word
//   position  sink    measured_position, target_position (signed)
//   drive     source  drive_value (unsigned, 16 bits)
//   cfg_*     write   cfg_we, cfg_index, cfg_data (no read-back)
//
// One word per cycle sustained while drive is ready; a sample passes the input
// register, the gain product register, then the accumulator and result register
// before its drive word is valid. The add and clamp close the loop combinationally.
// Reset loads the register defaults and the start output into the accumulator.
// A stalled drive word holds; each stage takes a new word whenever its
// successor is empty or moving, so the ready chain runs back to position.
`default_nettype none

module incremental_pid_clamped_unit #(
    parameter int POSITION_WIDTH = incp_pkg::DEFAULT_POSITION_WIDTH,
    parameter int FRACTION_BITS  = incp_pkg::DEFAULT_FRACTION_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    incp_in_if.sink                                   position,
    incp_out_if.source                                drive,
    input  wire logic                                 cfg_we,
    input  wire incp_pkg::cfg_index_t                 cfg_index,
    input  wire logic [incp_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import incp_pkg::*;

    localparam int PD_WIDTH = GAIN_WIDTH + 1 + POSITION_WIDTH + 2;
    localparam int PI_WIDTH = GAIN_WIDTH + POSITION_WIDTH + 1;

    cfg_t                       cfg;
    logic                       prod_valid;
    logic                       prod_ready;
    logic signed [PD_WIDTH-1:0] prod_d;
    logic signed [PI_WIDTH-1:0] prod_i;

    incp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    incp_product_stage #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_product_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .position   (position),
        .cfg        (cfg),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod_d     (prod_d),
        .prod_i     (prod_i)
    );

    incp_accum_stage #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_accum_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod_d     (prod_d),
        .prod_i     (prod_i),
        .drive      (drive)
    );

endmodule

`default_nettype wire
